/* design/deque_with_set_membership_unit_assert.svh */
// Assertion macros shared by the deque with set membership unit.
`ifndef DEQUE_WITH_SET_MEMBERSHIP_UNIT_ASSERT_SVH
`define DEQUE_WITH_SET_MEMBERSHIP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DQSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqsm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DQSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqsm: next-cycle check failed");

`endif

/* design/dqsm_pkg.sv */
// Types and constants of the deque with set membership unit.
package dqsm_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SET_ADD    = 3'd4,
        CMD_CONTAINS   = 3'd5,
        CMD_REMOVE     = 3'd6
    } cmd_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_LOAD_TAIL,
        CELL_SHL_FROM_MATCH
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } cmd_data_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [4:0]               count;
        logic                     is_empty;
    } rsp_data_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic              cmp;
        cell_op_t          op;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

    // Per-cell position flags.
    typedef struct packed {
        logic valid;
        logic tail;
    } cell_pos_t;

endpackage

/* design/dqsm_cell.sv */
// One storage cell of the deque: holds an element, compares it and shifts.
module dqsm_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dqsm_pkg::cell_ctrl_t             ctrl,
    input  dqsm_pkg::cell_pos_t              pos,
    input  logic [dqsm_pkg::DATA_W-1:0]      left,
    input  logic [dqsm_pkg::DATA_W-1:0]      right,
    input  logic                             seen_in,
    output logic [dqsm_pkg::DATA_W-1:0]      data,
    output logic                             seen_out
);

    logic [dqsm_pkg::DATA_W-1:0] data_reg;
    logic [dqsm_pkg::DATA_W-1:0] data_next;
    logic                        hit_reg;
    logic                        hit_next;

    // A match here or anywhere toward the front.
    assign seen_out = seen_in | hit_reg;
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            dqsm_pkg::CELL_HOLD:           data_next = data_reg;
            dqsm_pkg::CELL_SHR:            data_next = left;
            dqsm_pkg::CELL_SHL:            data_next = right;
            dqsm_pkg::CELL_LOAD_TAIL:      data_next = pos.tail ? ctrl.key : data_reg;
            dqsm_pkg::CELL_SHL_FROM_MATCH: data_next = seen_out ? right : data_reg;
            default:                       data_next = data_reg;
        endcase
    end

    assign hit_next = ctrl.cmp ? (pos.valid && (data_reg == ctrl.key)) : hit_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

/* design/deque_with_set_membership_unit.sv */
// Top level of the deque with set membership unit: cell chain and sequencer.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------
//  command | cmd_valid | cmd_stall | cmd_data (command, value)
//  result  | rsp_valid | rsp_stall | rsp_data (status .. empty)
//
// A command goes through these steps in order: compare in every cell,
// update the cell chain, then load the result register. A stalled result
// holds the report step until the result register frees. Reset empties the
// queue at once; cell contents are left as they are and never read before
// written.
module deque_with_set_membership_unit #(
    parameter int DEPTH = dqsm_pkg::DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  dqsm_pkg::cmd_data_t   cmd_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output dqsm_pkg::rsp_data_t   rsp_data
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    dqsm_pkg::state_t            state_reg;
    dqsm_pkg::state_t            state_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    dqsm_pkg::cmd_data_t         cmd_reg;
    dqsm_pkg::cmd_data_t         cmd_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    dqsm_pkg::rsp_data_t         rsp_data_reg;
    dqsm_pkg::rsp_data_t         rsp_data_next;

    dqsm_pkg::cell_ctrl_t        ctrl;
    dqsm_pkg::cell_pos_t         pos [DEPTH];
    logic [dqsm_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic                        seen [DEPTH+1];

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        hit_any;
    logic [IDX_W-1:0]            back_idx;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != dqsm_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign hit_any  = seen[DEPTH];
    assign back_idx = IDX_W'(fill_reg - 1'b1);

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [dqsm_pkg::DATA_W-1:0] left_val;
            logic [dqsm_pkg::DATA_W-1:0] right_val;

            assign pos[gi].valid = (FILL_W'(gi) < fill_reg);
            assign pos[gi].tail  = (FILL_W'(gi) == fill_reg);

            if (gi == 0)
            begin : g_first
                assign left_val = ctrl.key;
            end
            else
            begin : g_inner_left
                assign left_val = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_inner_right
                assign right_val = cell_data[gi+1];
            end

            dqsm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .pos      (pos[gi]),
                .left     (left_val),
                .right    (right_val),
                .seen_in  (seen[gi]),
                .data     (cell_data[gi]),
                .seen_out (seen[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        ctrl.cmp       = 1'b0;
        ctrl.op        = dqsm_pkg::CELL_HOLD;
        ctrl.key       = $unsigned(cmd_reg.value);

        case (state_reg)
            dqsm_pkg::ST_IDLE:
            begin
                // Compare against the incoming value in the same edge it transfers.
                ctrl.key = $unsigned(cmd_data.value);
                if (accept)
                begin
                    ctrl.cmp   = 1'b1;
                    cmd_next   = cmd_data;
                    state_next = dqsm_pkg::ST_EXEC;
                end
            end

            dqsm_pkg::ST_EXEC:
            begin
                status_next = dqsm_pkg::STATUS_OK;
                found_next  = 1'b0;
                case (dqsm_pkg::cmd_t'(cmd_reg.command))
                    dqsm_pkg::CMD_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = dqsm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.op   = dqsm_pkg::CELL_SHR;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    dqsm_pkg::CMD_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = dqsm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.op   = dqsm_pkg::CELL_LOAD_TAIL;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    dqsm_pkg::CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = dqsm_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            ctrl.op   = dqsm_pkg::CELL_SHL;
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    dqsm_pkg::CMD_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = dqsm_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                    dqsm_pkg::CMD_SET_ADD:
                    begin
                        if (hit_any)
                        begin
                            found_next = 1'b1;
                        end
                        else if (full)
                        begin
                            status_next = dqsm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.op   = dqsm_pkg::CELL_SHR;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    dqsm_pkg::CMD_CONTAINS:
                    begin
                        found_next = hit_any;
                    end
                    dqsm_pkg::CMD_REMOVE:
                    begin
                        if (hit_any)
                        begin
                            found_next = 1'b1;
                            ctrl.op    = dqsm_pkg::CELL_SHL_FROM_MATCH;
                            fill_next  = fill_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = dqsm_pkg::STATUS_OK;
                    end
                endcase
                state_next = dqsm_pkg::ST_REPORT;
            end

            dqsm_pkg::ST_REPORT:
            begin
                // Hold until the result register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.status       = status_reg;
                    rsp_data_next.found        = found_reg;
                    rsp_data_next.front_value  = empty ? '0 : $signed(cell_data[0]);
                    rsp_data_next.back_value   = empty ? '0 : $signed(cell_data[back_idx]);
                    rsp_data_next.count        = 5'(fill_reg);
                    rsp_data_next.is_empty     = empty;
                    state_next                 = dqsm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dqsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqsm_pkg::ST_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rsp_data_reg <= rsp_data_next;
    end

`include "deque_with_set_membership_unit_assert.svh"

    `DQSM_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(DEPTH))
    `DQSM_ASSERT_NEXT(a_accept_exec, accept, state_reg == dqsm_pkg::ST_EXEC)
    `DQSM_ASSERT_NEXT(a_full_keeps_fill, state_reg == dqsm_pkg::ST_EXEC && full && (cmd_reg.command == dqsm_pkg::CMD_PUSH_FRONT || cmd_reg.command == dqsm_pkg::CMD_PUSH_BACK), fill_reg == $past(fill_reg))

endmodule
